// ----- sv/audio_block_statistics_macros.svh -----
// ----------------------------------------------------------------------------
// Audio block statistics assertion macros
// Short forms for the concurrent checks used by the checker module.
// ----------------------------------------------------------------------------
`ifndef AUDIO_BLOCK_STATISTICS_MACROS_SVH
`define AUDIO_BLOCK_STATISTICS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABSTAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("abstat check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ABSTAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("abstat check failed");

// Next-cycle implication that is also checked across reset.
`define ABSTAT_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("abstat check failed");

`endif

// ----- sv/abstat_pkg.sv -----
// ----------------------------------------------------------------------------
// Audio block statistics package
// Types, constants and width helpers shared by the block's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package abstat_pkg;

    localparam int MAX_SAMPLES_DEF = 2048;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [11:0] sample_count;
        logic [15:0] max_magnitude;
        logic [30:0] average_power;
        logic [15:0] average_magnitude;
        logic [10:0] zero_crossings;
    } t_out_item;

    typedef enum logic [3:0] {
        S_ACCUM  = 4'b0001,
        S_LAST   = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_HOLD   = 4'b1000
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic mag_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Bits needed to hold a count of up to max_samples.
    function automatic int cnt_width(input int max_samples);
        return $clog2(max_samples + 1);
    endfunction

    // Bits of the sum of squares: each square is at most 2**30.
    function automatic int sq_width(input int max_samples);
        return 30 + cnt_width(max_samples);
    endfunction

    // Bits of the sum of magnitudes: each magnitude is at most 2**15.
    function automatic int mag_width(input int max_samples);
        return 15 + cnt_width(max_samples);
    endfunction

endpackage

`default_nettype wire

// ----- sv/abstat_dp.sv -----
// ----------------------------------------------------------------------------
// Audio block statistics datapath
// Squaring stage, block accumulators, two restoring dividers and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module abstat_dp import abstat_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_in_item   i_in_data,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_status,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_data
);

    localparam int CNT_W = cnt_width(MAX_SAMPLES);
    localparam int SQ_W  = sq_width(MAX_SAMPLES);
    localparam int MAG_W = mag_width(MAX_SAMPLES);

    logic               r_p1_valid;
    logic signed [15:0] r_p1_sample;
    logic [15:0]        r_p1_mag;
    logic [30:0]        r_p1_sq;

    logic [CNT_W-1:0]   r_count, n_count;
    logic [SQ_W-1:0]    r_sq_sum, n_sq_sum;
    logic [MAG_W-1:0]   r_mag_sum, n_mag_sum;
    logic [15:0]        r_peak, n_peak;
    logic [CNT_W-1:0]   r_cross, n_cross;
    logic signed [15:0] r_prev, n_prev;
    logic               r_have, n_have;

    logic [CNT_W-1:0]   r_div;
    logic [SQ_W-1:0]    r_pq;
    logic [MAG_W-1:0]   r_mq;
    logic [CNT_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_rm;
    logic [15:0]        r_res_peak;
    logic [CNT_W-1:0]   r_res_cross;

    logic               r_out_valid;
    t_out_item          r_out;

    logic [15:0]        w_mag_in;
    logic [31:0]        w_sq_in;
    logic [CNT_W:0]     w_pt, w_pdiff, w_mt, w_mdiff, w_div_ext;
    logic               w_pge, w_mge;

    assign w_mag_in = i_in_data.sample[15] ? 16'(-i_in_data.sample)
                                           : 16'(i_in_data.sample);
    assign w_sq_in  = {16'd0, w_mag_in} * {16'd0, w_mag_in};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_cmd.accept;
        end
        if (i_cmd.accept) begin
            r_p1_sample <= i_in_data.sample;
            r_p1_mag    <= w_mag_in;
            r_p1_sq     <= 31'(w_sq_in);
        end
    end

    always_comb begin
        n_count   = r_count;
        n_sq_sum  = r_sq_sum;
        n_mag_sum = r_mag_sum;
        n_peak    = r_peak;
        n_cross   = r_cross;
        n_prev    = r_prev;
        n_have    = r_have;
        if (r_p1_valid && (r_count != CNT_W'(MAX_SAMPLES))) begin
            n_count   = r_count + 1'b1;
            n_sq_sum  = r_sq_sum + SQ_W'(r_p1_sq);
            n_mag_sum = r_mag_sum + MAG_W'(r_p1_mag);
            if (r_p1_mag > r_peak) begin
                n_peak = r_p1_mag;
            end
            if (r_have && (((r_prev > 0) && (r_p1_sample < 0)) ||
                           ((r_prev < 0) && (r_p1_sample > 0)))) begin
                n_cross = r_cross + 1'b1;
            end
            n_prev = r_p1_sample;
            n_have = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.div_load) begin
            r_count   <= '0;
            r_sq_sum  <= '0;
            r_mag_sum <= '0;
            r_peak    <= '0;
            r_cross   <= '0;
            r_prev    <= '0;
            r_have    <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_sq_sum  <= n_sq_sum;
            r_mag_sum <= n_mag_sum;
            r_peak    <= n_peak;
            r_cross   <= n_cross;
            r_prev    <= n_prev;
            r_have    <= n_have;
        end
    end

    assign w_div_ext = {1'b0, r_div};
    assign w_pt      = {r_rp, r_pq[SQ_W-1]};
    assign w_pge     = (w_pt >= w_div_ext);
    assign w_pdiff   = w_pt - w_div_ext;
    assign w_mt      = {r_rm, r_mq[MAG_W-1]};
    assign w_mge     = (w_mt >= w_div_ext);
    assign w_mdiff   = w_mt - w_div_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div       <= n_count;
            r_pq        <= n_sq_sum;
            r_mq        <= n_mag_sum;
            r_rp        <= '0;
            r_rm        <= '0;
            r_res_peak  <= n_peak;
            r_res_cross <= n_cross;
        end else begin
            if (i_cmd.div_step) begin
                r_rp <= w_pge ? w_pdiff[CNT_W-1:0] : w_pt[CNT_W-1:0];
                r_pq <= {r_pq[SQ_W-2:0], w_pge};
            end
            if (i_cmd.mag_step) begin
                r_rm <= w_mge ? w_mdiff[CNT_W-1:0] : w_mt[CNT_W-1:0];
                r_mq <= {r_mq[MAG_W-2:0], w_mge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out.sample_count      <= 12'(r_div);
            r_out.max_magnitude     <= r_res_peak;
            r_out.average_power     <= (r_div == '0) ? '0 : 31'(r_pq);
            r_out.average_magnitude <= (r_div == '0) ? '0 : 16'(r_mq);
            r_out.zero_crossings    <= 11'(r_res_cross);
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

`default_nettype wire

// ----- sv/abstat_ctrl.sv -----
// ----------------------------------------------------------------------------
// Audio block statistics controller
// Sequences accumulation, the end-of-block division and the result load.
// ----------------------------------------------------------------------------
`default_nettype none

module abstat_ctrl import abstat_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_last,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam int SQ_W   = sq_width(MAX_SAMPLES);
    localparam int MAG_W  = mag_width(MAX_SAMPLES);
    localparam int STEP_W = $clog2(SQ_W);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                w_accept;

    assign o_in_ready = (r_state == S_ACCUM);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        o_cmd          = '0;
        o_cmd.accept   = w_accept;
        unique case (r_state)
            S_ACCUM: begin
                if (w_accept && i_in_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                o_cmd.div_load = 1'b1;
                n_step         = STEP_W'(SQ_W - 1);
                n_state        = S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                o_cmd.mag_step = (r_step < STEP_W'(MAG_W));
                n_step         = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_ACCUM;
                end
            end
            default: begin
                n_state = S_ACCUM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

// ----- sv/audio_block_statistics.sv -----
// ----------------------------------------------------------------------------
// Audio block statistics
// Per-block sample count, peak magnitude, average power, average magnitude
// and zero-crossing count of a stream of signed 16-bit samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a block is open; after the request
// that carries the last flag, the input stays not ready through the S_LAST
// state, in which the pipeline drains into the dividers, the S_DIVIDE steps
// of the two shared-step restoring dividers, and the S_HOLD state that moves
// the result into the output register, longer if a previous result is still
// waiting to be taken. Samples past MAX_SAMPLES in one block are dropped,
// though their last flag still closes the block.
`default_nettype none

module audio_block_statistics import abstat_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    abstat_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    abstat_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- sv/abstat_checker.sv -----
// ----------------------------------------------------------------------------
// Audio block statistics checker
// Port-level checks on request flow and result values, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "audio_block_statistics_macros.svh"

module abstat_checker import abstat_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire t_in_item  i_in_data,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_data
);

    `ABSTAT_ASSERT_NXT(a_last_closes_input, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_data.last, !i_in_ready)
    `ABSTAT_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))
    `ABSTAT_ASSERT_IMP(a_avg_below_peak, i_clk, i_rst_n, i_out_valid, i_out_data.average_magnitude <= i_out_data.max_magnitude)
    `ABSTAT_ASSERT_IMP(a_power_range, i_clk, i_rst_n, i_out_valid, i_out_data.average_power <= 31'h4000_0000)
    `ABSTAT_ASSERT_NXT_ALWAYS(a_reset_state, i_clk, !i_rst_n, !i_out_valid && i_in_ready)

endmodule

bind audio_block_statistics abstat_checker u_abstat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

`default_nettype wire

// ----- tb/tb_audio_block_statistics.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Audio block statistics testbench
// Drives blocks of signed samples through the request handshake, predicts each
// block's count, peak, averages and zero crossings, and checks every result
// against the prediction under varying sender idling and receiver stalls.
// ----------------------------------------------------------------------------

module tb_audio_block_statistics;
    import abstat_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_TAIL  = 100;
    localparam int RANDOM_ITEMS_PER_PHASE = 80;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic receiver_held = 1'b0;
    int  hold_length = 0;
    event start_hold;
    int  cycle_count = 0;
    int  failures = 0;

    // Running statistics of the block that is currently open.
    int               block_count;
    longint unsigned  block_square_sum;
    longint unsigned  block_magnitude_sum;
    int unsigned      block_peak;
    int               block_crossings;
    int               block_prev_sample;
    bit               block_has_prev;
    t_out_item        pending_stats[$];

    audio_block_statistics #(
        .MAX_SAMPLES(MAX_SAMPLES_DEF)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic void clear_block();
        block_count = 0;
        block_square_sum = 0;
        block_magnitude_sum = 0;
        block_peak = 0;
        block_crossings = 0;
        block_prev_sample = 0;
        block_has_prev = 1'b0;
    endfunction

    function automatic void accumulate_sample(t_in_item item);
        int          s;
        int unsigned mag;
        t_out_item   stats;
        s = int'(item.sample);
        if (block_count < MAX_SAMPLES_DEF) begin
            mag = (s < 0) ? -s : s;
            block_count++;
            block_square_sum += longint'(mag) * longint'(mag);
            block_magnitude_sum += 64'(mag);
            if (mag > block_peak) begin
                block_peak = mag;
            end
            if (block_has_prev && ((block_prev_sample > 0 && s < 0) ||
                                   (block_prev_sample < 0 && s > 0))) begin
                block_crossings++;
            end
            block_prev_sample = s;
            block_has_prev = 1'b1;
        end
        if (item.last) begin
            stats.sample_count = 12'(block_count);
            stats.max_magnitude = 16'(block_peak);
            stats.average_power = '0;
            stats.average_magnitude = '0;
            if (block_count != 0) begin
                stats.average_power =
                    31'(block_square_sum / longint'(block_count));
                stats.average_magnitude =
                    16'(block_magnitude_sum / longint'(block_count));
            end
            stats.zero_crossings = 11'(block_crossings);
            pending_stats.push_back(stats);
            clear_block();
        end
    endfunction

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= 10) begin
            $display("Mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endfunction

    function automatic void check_field(string field, longint want, longint got);
        if (want != got) begin
            note_failure($sformatf("%s expected %0d, got %0d", field, want, got));
        end
    endfunction

    function automatic void check_stats(t_out_item got);
        t_out_item want;
        if (pending_stats.size() == 0) begin
            note_failure("result arrived with no block outstanding");
        end else begin
            want = pending_stats.pop_front();
            check_field("sample_count", longint'(want.sample_count),
                        longint'(got.sample_count));
            check_field("max_magnitude", longint'(want.max_magnitude),
                        longint'(got.max_magnitude));
            check_field("average_power", longint'(want.average_power),
                        longint'(got.average_power));
            check_field("average_magnitude", longint'(want.average_magnitude),
                        longint'(got.average_magnitude));
            check_field("zero_crossings", longint'(want.zero_crossings),
                        longint'(got.zero_crossings));
        end
    endfunction

    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                check_stats(out_data);
            end
            out_ready <= !receiver_held && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        forever begin
            @(start_hold);
            receiver_held <= 1'b1;
            repeat (hold_length) @(posedge clk);
            receiver_held <= 1'b0;
        end
    end

    task automatic send_sample(input int value, input bit last_flag);
        int       gap;
        t_in_item item;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.sample = 16'(value);
        item.last = last_flag;
        in_valid <= 1'b1;
        in_data <= item;
        do begin
            @(posedge clk);
        end while (!in_ready);
        accumulate_sample(item);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_all_results();
        while (pending_stats.size() != 0) begin
            @(posedge clk);
        end
    endtask

    function automatic int random_sample(bit alternating, bit polarity);
        int pick;
        pick = $urandom_range(9);
        if (alternating && pick != 0) begin
            return polarity ? int'($urandom_range(32767, 1))
                            : 0 - int'($urandom_range(32768, 1));
        end
        case (pick)
            0, 1, 2, 3: return int'($signed(16'($urandom)));
            4, 5:       return int'($urandom_range(8)) - 4;
            6: begin
                case ($urandom_range(4))
                    0:       return -32768;
                    1:       return 32767;
                    2:       return -1;
                    3:       return 1;
                    default: return 0;
                endcase
            end
            default:    return int'($urandom_range(400)) - 200;
        endcase
    endfunction

    task automatic send_random_block(input int length);
        bit alternating;
        bit polarity;
        alternating = ($urandom_range(2) == 0);
        polarity = 1'($urandom_range(1));
        for (int n = 0; n < length; n++) begin
            send_sample(random_sample(alternating, polarity), n == length - 1);
            polarity = !polarity;
        end
    endtask

    task automatic test_directed_extremes();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_sample(-32768, 1'b1);
        send_sample(32767, 1'b1);
        send_sample(0, 1'b1);
        send_sample(5, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-3, 1'b0);
        send_sample(0, 1'b0);
        send_sample(7, 1'b0);
        send_sample(-1, 1'b1);
        send_sample(1, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(-1, 1'b1);
        send_sample(-32768, 1'b0);
        send_sample(32767, 1'b0);
        send_sample(-32768, 1'b0);
        send_sample(32767, 1'b1);
        send_sample(-32768, 1'b0);
        send_sample(-32768, 1'b0);
        send_sample(-32768, 1'b1);
        send_sample(21845, 1'b0);
        send_sample(-21846, 1'b1);
        stop_sending();
        wait_all_results();
    endtask

    task automatic test_block_overflow();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int n = 0; n < MAX_SAMPLES_DEF; n++) begin
            send_sample((n % 2 == 0) ? 32767 : -32768, 1'b0);
        end
        send_sample(32767, 1'b0);
        send_sample(-32768, 1'b0);
        for (int n = 0; n < 7; n++) begin
            send_sample(random_sample(1'b0, 1'b0), 1'b0);
        end
        send_sample(1, 1'b1);
        stop_sending();
        wait_all_results();
    endtask

    task automatic test_random_blocks();
        int items_sent;
        int length;
        int r;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            items_sent = 0;
            while (items_sent < RANDOM_ITEMS_PER_PHASE) begin
                r = $urandom_range(99);
                if (r < 85) begin
                    length = $urandom_range(12, 1);
                end else if (r < 98) begin
                    length = $urandom_range(100, 13);
                end else begin
                    length = $urandom_range(300, 101);
                end
                send_random_block(length);
                items_sent += length;
            end
        end
        stop_sending();
        wait_all_results();
    endtask

    task automatic test_receiver_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_length = 600;
        -> start_hold;
        for (int b = 0; b < 6; b++) begin
            send_random_block(8);
        end
        stop_sending();
        wait_all_results();
    endtask

    initial begin
        clear_block();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_block_overflow();
        test_random_blocks();
        test_receiver_backpressure();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
